### rtl/alpi_pkg.sv
// Shared types, codes and constants of the ordered address list block.
// Used by the list cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package alpi_pkg;

    // Default number of list slots.
    localparam int LIST_DEPTH_DEF = 16;

    // Configuration register indexes.
    localparam int            REG_IDX_W       = 1;
    localparam int            REG_DATA_W      = 3;
    localparam logic [REG_IDX_W-1:0] REG_FAMILY_PREF = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROTATE      = 1'd1;

    // Family preference codes; the unused codes act as no preference.
    localparam logic [2:0] PREF_NONE    = 3'd0;
    localparam logic [2:0] PREF_V4      = 3'd1;
    localparam logic [2:0] PREF_V6      = 3'd2;
    localparam logic [2:0] PREF_V4_ONLY = 3'd3;
    localparam logic [2:0] PREF_V6_ONLY = 3'd4;

    // Position that rotation moves the first other-family entry to (one based).
    localparam int ROTATE_POS = 2;

    // One list entry.
    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] scope;
    } slot_t;

    // What a cell loads at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } cell_op_t;

endpackage

`default_nettype wire

### rtl/alpi_if.sv
// Valid/ready channel interfaces for the address list block.
// Self-contained; the field widths follow slot_t in alpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface alpi_in_if;
    logic        valid;
    logic        ready;
    logic        has_address;
    logic        is_ipv6;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [31:0] addr_scope;
    logic        end_of_list;

    modport source (
        output valid, has_address, is_ipv6, addr_high, addr_low, addr_scope, end_of_list,
        input  ready
    );
    modport sink (
        input  valid, has_address, is_ipv6, addr_high, addr_low, addr_scope, end_of_list,
        output ready
    );
endinterface

interface alpi_out_if;
    logic        valid;
    logic        ready;
    logic        entry_is_ipv6;
    logic [63:0] entry_addr_high;
    logic [63:0] entry_addr_low;
    logic [31:0] entry_scope;
    logic        no_entries;
    logic        entry_last;

    modport source (
        output valid, entry_is_ipv6, entry_addr_high, entry_addr_low, entry_scope,
               no_entries, entry_last,
        input  ready
    );
    modport sink (
        input  valid, entry_is_ipv6, entry_addr_high, entry_addr_low, entry_scope,
               no_entries, entry_last,
        output ready
    );
endinterface

`default_nettype wire

### rtl/address_list_preference_insert.sv
// Top level of the ordered address list builder: a chain of list cells plus control.
// Depends on alpi_pkg, alpi_in_if / alpi_out_if and alpi_cell.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The in_ch channel takes one word per item: an optional address offer and an
// end-of-list mark. The out_ch channel returns the closed list, one entry per
// word, with entry_last on the final word; an empty list gives a single word
// with no_entries and entry_last set. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Throughput: while the block is idle, an item without the end mark is accepted
// every cycle, since all cells compare the offer and shift in parallel within the
// accept cycle. A closing item is accepted, then the rotate step moves the first
// other-family entry one place per swap toward position two (up to LIST_DEPTH-2
// places), then the entries are emitted in order, the chain shifting toward cell
// 0 as each word is loaded. Without rotation, the first result word passes through
// the rotate step and the emit state before it reaches the output register.
// in_ch.ready is low from the closing item until its last word has been loaded
// into the output register. When the receiver stalls, the output register holds
// its word and emission pauses; the list stays in the cells. Reset empties the
// list, drops any pending output word and sets both configuration registers to zero.
module address_list_preference_insert #(
    parameter int LIST_DEPTH = alpi_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    alpi_in_if.sink                             in_ch,
    alpi_out_if.source                          out_ch,
    input  wire logic                           cfg_we,
    input  wire logic [alpi_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [alpi_pkg::REG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROTATE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      pref_reg, pref_next;
    logic            rot_reg, rot_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            out_valid_reg, out_valid_next;
    alpi_pkg::slot_t out_slot_reg, out_slot_next;
    logic            out_empty_reg, out_empty_next;
    logic            out_last_reg, out_last_next;

    // The offer as it would be stored: IPv4 keeps only the top 32 address bits.
    alpi_pkg::slot_t offer;

    always_comb
    begin
        offer.is_ipv6   = in_ch.is_ipv6;
        offer.addr_high = in_ch.is_ipv6 ? in_ch.addr_high
                                        : {in_ch.addr_high[63:32], 32'd0};
        offer.addr_low  = in_ch.is_ipv6 ? in_ch.addr_low : 64'd0;
        offer.scope     = in_ch.addr_scope;
    end

    alpi_pkg::slot_t     slot_q   [LIST_DEPTH];
    alpi_pkg::cell_op_t  cell_op  [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] occ;
    logic [LIST_DEPTH-1:0] hit;
    logic [LIST_DEPTH-1:0] brk;
    logic [LIST_DEPTH-1:0] stop_before;
    logic [LIST_DEPTH-1:0] first_free;
    logic [LIST_DEPTH-1:0] diff;
    logic [LIST_DEPTH-1:0] diff_before;
    logic [LIST_DEPTH-1:0] first_diff_far;
    logic [LIST_DEPTH-1:0] pull_next;

    logic in_accept;
    logic excluded;
    logic full;
    logic dup;
    logic ins_en;
    logic rot_swap;
    logic emit_shift;
    logic out_free;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    // A preferred-family offer stops at the first occupied entry of the other
    // family; the stop flag ripples along the chain from cell 0.
    genvar i;
    generate
        for (i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            assign occ[i] = (count_reg > CW'(i));
            assign brk[i] = occ[i] &&
                ((pref_reg == alpi_pkg::PREF_V4 && !offer.is_ipv6 && slot_q[i].is_ipv6) ||
                 (pref_reg == alpi_pkg::PREF_V6 && offer.is_ipv6 && !slot_q[i].is_ipv6));

            if (i == 0)
            begin : g_head
                assign stop_before[i]    = 1'b0;
                assign first_free[i]     = !occ[i];
                assign diff[i]           = 1'b0;
                assign diff_before[i]    = 1'b0;
                assign first_diff_far[i] = 1'b0;
            end
            else
            begin : g_body
                assign stop_before[i] = stop_before[i-1] || brk[i-1];
                assign first_free[i]  = !occ[i] && occ[i-1];
                assign diff[i]        = occ[i] && (slot_q[i].is_ipv6 != slot_q[0].is_ipv6);
                assign diff_before[i] = diff_before[i-1] || diff[i-1];
                // The first other-family entry only needs to move when it sits
                // beyond the rotation position.
                if (i >= alpi_pkg::ROTATE_POS)
                begin : g_far
                    assign first_diff_far[i] = diff[i] && !diff_before[i];
                end
                else
                begin : g_near
                    assign first_diff_far[i] = 1'b0;
                end
            end

            if (i < LIST_DEPTH - 1)
            begin : g_pull
                assign pull_next[i] = first_diff_far[i+1];
            end
            else
            begin : g_pull_end
                assign pull_next[i] = 1'b0;
            end

            alpi_pkg::slot_t prev_in;
            alpi_pkg::slot_t next_in;

            if (i == 0)
            begin : g_prev0
                assign prev_in = '0;
            end
            else
            begin : g_prev
                assign prev_in = slot_q[i-1];
            end

            if (i == LIST_DEPTH - 1)
            begin : g_next_end
                assign next_in = '0;
            end
            else
            begin : g_next
                assign next_in = slot_q[i+1];
            end

            // Insertion shifts the tail up one cell; rotation swaps the first
            // other-family entry with its lower neighbor; emission shifts down.
            always_comb
            begin
                cell_op[i] = alpi_pkg::CELL_HOLD;
                if (ins_en)
                begin
                    if (stop_before[i])
                    begin
                        cell_op[i] = alpi_pkg::CELL_PREV;
                    end
                    else if (brk[i] || first_free[i])
                    begin
                        cell_op[i] = alpi_pkg::CELL_LOAD;
                    end
                end
                else if (rot_swap)
                begin
                    if (pull_next[i])
                    begin
                        cell_op[i] = alpi_pkg::CELL_NEXT;
                    end
                    else if (first_diff_far[i])
                    begin
                        cell_op[i] = alpi_pkg::CELL_PREV;
                    end
                end
                else if (emit_shift)
                begin
                    cell_op[i] = alpi_pkg::CELL_NEXT;
                end
            end

            alpi_cell u_cell (
                .clk       (clk),
                .op        (cell_op[i]),
                .new_slot  (offer),
                .prev_slot (prev_in),
                .next_slot (next_in),
                .occupied  (occ[i]),
                .slot_q    (slot_q[i]),
                .hit       (hit[i])
            );
        end
    endgenerate

    // The offer is a duplicate only if it matches an entry ahead of its
    // insertion point.
    assign dup      = |(hit & ~stop_before);
    assign excluded = (in_ch.is_ipv6 && pref_reg == alpi_pkg::PREF_V4_ONLY) ||
                      (!in_ch.is_ipv6 && pref_reg == alpi_pkg::PREF_V6_ONLY);
    assign full     = (count_reg == CW'(LIST_DEPTH));
    assign ins_en   = in_accept && in_ch.has_address && !excluded && !full && !dup;

    assign rot_swap   = (state_reg == ST_ROTATE) && rot_reg && (|first_diff_far);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign emit_shift = (state_reg == ST_EMIT) && out_free && (count_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ins_en)
                begin
                    count_next = count_reg + CW'(1);
                end
                if (in_accept && in_ch.end_of_list)
                begin
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                // Each swap moves the other-family entry one place down.
                if (!rot_swap)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        out_slot_next  = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        out_slot_next  = slot_q[0];
                        out_empty_next = 1'b0;
                        out_last_next  = (count_reg == CW'(1));
                        count_next     = count_reg - CW'(1);
                        if (count_reg == CW'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pref_next = pref_reg;
        rot_next  = rot_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                alpi_pkg::REG_FAMILY_PREF: pref_next = cfg_data;
                alpi_pkg::REG_ROTATE:      rot_next  = cfg_data[0];
                default:                   pref_next = pref_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pref_reg      <= alpi_pkg::PREF_NONE;
            rot_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pref_reg      <= pref_next;
            rot_reg       <= rot_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg  <= out_slot_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.entry_is_ipv6   = out_slot_reg.is_ipv6;
    assign out_ch.entry_addr_high = out_slot_reg.addr_high;
    assign out_ch.entry_addr_low  = out_slot_reg.addr_low;
    assign out_ch.entry_scope     = out_slot_reg.scope;
    assign out_ch.no_entries      = out_empty_reg;
    assign out_ch.entry_last      = out_last_reg;

endmodule

`default_nettype wire

### rtl/alpi_cell.sv
// One slot of the address list chain: holds an entry and compares it with the offer.
// Depends on alpi_pkg for slot_t and cell_op_t.
`timescale 1ns / 1ps
`default_nettype none

module alpi_cell (
    input  wire logic              clk,
    input  wire alpi_pkg::cell_op_t op,
    input  wire alpi_pkg::slot_t   new_slot,
    input  wire alpi_pkg::slot_t   prev_slot,
    input  wire alpi_pkg::slot_t   next_slot,
    input  wire logic              occupied,
    output alpi_pkg::slot_t        slot_q,
    output logic                   hit
);

    alpi_pkg::slot_t slot_reg;
    alpi_pkg::slot_t slot_next;

    always_comb
    begin
        unique case (op)
            alpi_pkg::CELL_HOLD: slot_next = slot_reg;
            alpi_pkg::CELL_LOAD: slot_next = new_slot;
            alpi_pkg::CELL_PREV: slot_next = prev_slot;
            alpi_pkg::CELL_NEXT: slot_next = next_slot;
            default:             slot_next = slot_reg;
        endcase
    end

    // Payload only: occupancy is kept by the fill count at the top level.
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_q = slot_reg;
    assign hit    = occupied && (slot_reg == new_slot);

endmodule

`default_nettype wire
